// File: design/sat_pkg.sv
package sat_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ID_W = 16;
    localparam int TIME_W = 48;
    localparam int MASK_W = 8;

    localparam logic [ID_W-1:0] EMPTY_OWNER = 16'hFFFF;

    localparam logic [2:0] CMD_SET_LAST = 3'd0;
    localparam logic [2:0] CMD_CLAIM    = 3'd1;
    localparam logic [2:0] CMD_NEXT     = 3'd2;
    localparam logic [2:0] CMD_EVICT    = 3'd3;
    localparam logic [2:0] CMD_DELETE   = 3'd4;
    localparam logic [2:0] CMD_LOOKUP   = 3'd5;
    localparam logic [2:0] CMD_ALLOC    = 3'd6;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic              en;
        slot_t             addr;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
        logic              used;
    } slot_wr_t;

    typedef struct packed {
        logic locked;
        logic id_match;
        logic older;
        logic free_slot;
    } slot_cmp_t;

    // Next slot in scan order, wrapping at the end of the table.
    function automatic slot_t slot_inc(slot_t s);
        slot_t r;
        if (s == slot_t'(SLOT_COUNT - 1))
            r = '0;
        else
            r = s + slot_t'(1);
        return r;
    endfunction

    // Reduces a 3-bit slot number modulo the table size.
    function automatic slot_t slot_mod(logic [2:0] v);
        logic [4:0] w;
        w = 5'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (w >= 5'(SLOT_COUNT))
                w = w - 5'(SLOT_COUNT);
        end
        return slot_t'(w);
    endfunction

    // Slots beyond the mask width have no lock bit and count as unlocked.
    function automatic logic slot_locked(logic [MASK_W-1:0] mask, slot_t s);
        logic [3:0] w;
        logic r;
        w = 4'(s);
        if (w < 4'd8)
            r = mask[w[2:0]];
        else
            r = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] slot_res(slot_t s);
        logic [3:0] w;
        w = 4'(s);
        return w[2:0];
    endfunction

endpackage

// File: design/sat_slot_store.sv
module sat_slot_store
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  sat_pkg::slot_wr_t               wr,
    input  sat_pkg::slot_t                  rd_addr,
    output logic [sat_pkg::ID_W-1:0]        rd_id,
    output logic [sat_pkg::TIME_W-1:0]      rd_stamp,
    output logic                            rd_used
);

    logic [sat_pkg::ID_W-1:0]   owner_reg [sat_pkg::SLOT_COUNT];
    logic [sat_pkg::TIME_W-1:0] stamp_reg [sat_pkg::SLOT_COUNT];
    logic [sat_pkg::SLOT_COUNT-1:0] used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sat_pkg::SLOT_COUNT; i++)
            begin
                owner_reg[i] <= sat_pkg::EMPTY_OWNER;
                stamp_reg[i] <= '0;
            end
            used_reg <= '0;
        end
        else if (wr.en)
        begin
            owner_reg[wr.addr] <= wr.id;
            stamp_reg[wr.addr] <= wr.stamp;
            used_reg[wr.addr]  <= wr.used;
        end
    end

    assign rd_id    = owner_reg[rd_addr];
    assign rd_stamp = stamp_reg[rd_addr];
    assign rd_used  = used_reg[rd_addr];

endmodule

// File: design/sat_scan_unit.sv
module sat_scan_unit
(
    input  sat_pkg::slot_t                  slot,
    input  logic [sat_pkg::ID_W-1:0]        slot_id,
    input  logic [sat_pkg::TIME_W-1:0]      slot_stamp,
    input  logic                            slot_used,
    input  logic [sat_pkg::MASK_W-1:0]      lock_mask,
    input  logic [sat_pkg::ID_W-1:0]        fsm_id,
    input  logic [sat_pkg::TIME_W-1:0]      oldest,
    output sat_pkg::slot_cmp_t              cmp
);

    logic locked;

    assign locked        = sat_pkg::slot_locked(lock_mask, slot);
    assign cmp.locked    = locked;
    assign cmp.id_match  = (slot_id == fsm_id);
    assign cmp.older     = (slot_stamp < oldest);
    assign cmp.free_slot = !locked && !slot_used;

endmodule

// File: design/slot_table_lru_allocator.sv
// Slot table allocator: one command per input transfer, one result transfer per
// command. set_last, claim and the unused code do not scan the table. The
// scanning commands step through the table one slot per cycle with a single
// shared compare unit; allocate that finds no free slot runs a second pass for
// eviction. Lookups, deletes and free-slot searches stop at the first hit. The
// block takes a new command only when the previous one is done, but a finished
// result may still wait in the output register.
module slot_table_lru_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], slot_index[5:3], fsm_id[21:6], lock_mask[29:22], time_now[77:30]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_slot[2:0], found[3], running[4]
    output logic [7:0]  m_axis_tdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [sat_pkg::ID_W-1:0] id_reg, id_next;
    logic [sat_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic [sat_pkg::TIME_W-1:0] now_reg, now_next;
    sat_pkg::slot_t last_reg, last_next;
    sat_pkg::slot_t ptr_reg, ptr_next;
    sat_pkg::slot_t first_reg, first_next;
    sat_pkg::slot_t count_reg, count_next;
    logic phase_reg, phase_next;
    logic any_reg, any_next;
    sat_pkg::slot_t best_reg, best_next;
    logic [sat_pkg::TIME_W-1:0] oldest_reg, oldest_next;
    sat_pkg::slot_t res_reg, res_next;
    logic found_reg, found_next;
    logic running_reg, running_next;
    logic claim_reg, claim_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;

    logic [2:0] in_cmd;
    sat_pkg::slot_t in_slot;
    logic [sat_pkg::ID_W-1:0] rd_id;
    logic [sat_pkg::TIME_W-1:0] rd_stamp;
    logic rd_used;
    sat_pkg::slot_cmp_t cmp;
    sat_pkg::slot_wr_t wr;
    logic last_step;
    logic evicting;

    assign in_cmd  = s_axis_tdata[2:0];
    assign in_slot = sat_pkg::slot_mod(s_axis_tdata[5:3]);

    sat_slot_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_addr  (ptr_reg),
        .rd_id    (rd_id),
        .rd_stamp (rd_stamp),
        .rd_used  (rd_used)
    );

    sat_scan_unit u_scan
    (
        .slot       (ptr_reg),
        .slot_id    (rd_id),
        .slot_stamp (rd_stamp),
        .slot_used  (rd_used),
        .lock_mask  (mask_reg),
        .fsm_id     (id_reg),
        .oldest     (oldest_reg),
        .cmp        (cmp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign last_step = (count_reg == sat_pkg::slot_t'(sat_pkg::SLOT_COUNT - 1));
    // Eviction runs for evict_lru and for the second pass of allocate.
    assign evicting  = (cmd_reg == sat_pkg::CMD_EVICT) ||
                       ((cmd_reg == sat_pkg::CMD_ALLOC) && phase_reg);

    always_comb
    begin
        wr.en    = 1'b0;
        wr.addr  = res_reg;
        wr.id    = sat_pkg::EMPTY_OWNER;
        wr.stamp = '0;
        wr.used  = 1'b0;
        if (state_reg == ST_WRITE)
        begin
            wr.en = 1'b1;
            if (claim_reg)
            begin
                wr.id    = id_reg;
                wr.stamp = now_reg;
                wr.used  = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        mask_next      = mask_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        any_next       = any_reg;
        best_next      = best_reg;
        oldest_next    = oldest_reg;
        res_next       = res_reg;
        found_next     = found_reg;
        running_next   = running_reg;
        claim_next     = claim_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next     = in_cmd;
                    id_next      = s_axis_tdata[21:6];
                    mask_next    = s_axis_tdata[29:22];
                    now_next     = s_axis_tdata[77:30];
                    ptr_next     = sat_pkg::slot_inc(last_reg);
                    first_next   = sat_pkg::slot_inc(last_reg);
                    count_next   = '0;
                    phase_next   = 1'b0;
                    any_next     = 1'b0;
                    oldest_next  = '0;
                    res_next     = '0;
                    found_next   = 1'b0;
                    running_next = 1'b0;
                    claim_next   = 1'b0;
                    case (in_cmd)
                        sat_pkg::CMD_SET_LAST:
                        begin
                            last_next  = in_slot;
                            res_next   = in_slot;
                            found_next = 1'b1;
                            state_next = ST_RESULT;
                        end
                        sat_pkg::CMD_CLAIM:
                        begin
                            res_next   = in_slot;
                            found_next = 1'b1;
                            claim_next = 1'b1;
                            state_next = ST_WRITE;
                        end
                        sat_pkg::CMD_NEXT,
                        sat_pkg::CMD_EVICT,
                        sat_pkg::CMD_DELETE,
                        sat_pkg::CMD_LOOKUP,
                        sat_pkg::CMD_ALLOC:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                ptr_next   = sat_pkg::slot_inc(ptr_reg);
                count_next = count_reg + sat_pkg::slot_t'(1);
                if (evicting)
                begin
                    if (!cmp.locked && (!any_reg || cmp.older))
                    begin
                        any_next    = 1'b1;
                        best_next   = ptr_reg;
                        oldest_next = rd_stamp;
                    end
                    if (last_step)
                    begin
                        if (!cmp.locked && (!any_reg || cmp.older))
                        begin
                            res_next   = ptr_reg;
                            found_next = 1'b1;
                            state_next = ST_WRITE;
                        end
                        else if (any_reg)
                        begin
                            res_next   = best_reg;
                            found_next = 1'b1;
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                end
                else
                begin
                    case (cmd_reg)
                        sat_pkg::CMD_NEXT:
                        begin
                            if (!cmp.locked)
                            begin
                                res_next   = ptr_reg;
                                found_next = 1'b1;
                                state_next = ST_RESULT;
                            end
                            else if (last_step)
                            begin
                                res_next   = first_reg;
                                state_next = ST_RESULT;
                            end
                        end
                        sat_pkg::CMD_DELETE:
                        begin
                            if (!cmp.locked && cmp.id_match)
                            begin
                                res_next   = ptr_reg;
                                found_next = 1'b1;
                                state_next = ST_WRITE;
                            end
                            else if (last_step)
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        sat_pkg::CMD_LOOKUP:
                        begin
                            if (cmp.id_match)
                            begin
                                res_next     = ptr_reg;
                                found_next   = 1'b1;
                                running_next = cmp.locked;
                                state_next   = ST_RESULT;
                            end
                            else if (last_step)
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        sat_pkg::CMD_ALLOC:
                        begin
                            if (cmp.free_slot)
                            begin
                                res_next   = ptr_reg;
                                found_next = 1'b1;
                                state_next = ST_RESULT;
                            end
                            else if (last_step)
                            begin
                                // No free slot: rescan from the start for eviction.
                                phase_next = 1'b1;
                                ptr_next   = first_reg;
                                count_next = '0;
                                any_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_WRITE:
            begin
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, running_reg, found_reg,
                                      sat_pkg::slot_res(res_reg)};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        mask_reg     <= mask_next;
        now_reg      <= now_next;
        ptr_reg      <= ptr_next;
        first_reg    <= first_next;
        count_reg    <= count_next;
        phase_reg    <= phase_next;
        any_reg      <= any_next;
        best_reg     <= best_next;
        oldest_reg   <= oldest_next;
        res_reg      <= res_next;
        found_reg    <= found_next;
        running_reg  <= running_next;
        claim_reg    <= claim_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: tb/slot_table_lru_allocator_tb.sv
`timescale 1ns / 100ps

module slot_table_lru_allocator_tb;

    localparam logic [2:0]                 CMD_UNUSED = 3'd7;
    localparam logic [sat_pkg::MASK_W-1:0] NONE_LOCKED = '0;
    localparam logic [sat_pkg::MASK_W-1:0] ALL_LOCKED = '1;
    localparam logic [sat_pkg::TIME_W-1:0] TIME_MAX = '1;
    localparam int                         RANDOM_PER_PHASE = 584;

    typedef struct packed {
        logic       running;
        logic       found;
        logic [2:0] slot;
    } reply_t;

    // Mirrors the slot table and checks every result transfer against it.
    class slot_table_tracker;
        sat_pkg::slot_t             last_slot;
        logic [sat_pkg::ID_W-1:0]   owner [sat_pkg::SLOT_COUNT];
        logic [sat_pkg::TIME_W-1:0] stamp [sat_pkg::SLOT_COUNT];
        logic                       in_use [sat_pkg::SLOT_COUNT];
        reply_t                     expected_replies [$];
        reply_t                     last_reply;
        int                         mismatches;

        function new();
            last_slot = '0;
            mismatches = 0;
            for (int i = 0; i < sat_pkg::SLOT_COUNT; i++)
            begin
                clear_slot(sat_pkg::slot_t'(i));
            end
        endfunction

        function void clear_slot(sat_pkg::slot_t s);
            owner[s] = sat_pkg::EMPTY_OWNER;
            stamp[s] = '0;
            in_use[s] = 1'b0;
        endfunction

        function sat_pkg::slot_t scan_at(int k);
            return sat_pkg::slot_t'((int'(last_slot) + k + 1) % sat_pkg::SLOT_COUNT);
        endfunction

        // Slots past the mask width carry no lock bit.
        function logic locked(logic [sat_pkg::MASK_W-1:0] mask, sat_pkg::slot_t s);
            return (int'(s) < sat_pkg::MASK_W) ? mask[s] : 1'b0;
        endfunction

        function logic evict_oldest(logic [sat_pkg::MASK_W-1:0] mask,
                                    output sat_pkg::slot_t slot);
            logic                       any;
            logic [sat_pkg::TIME_W-1:0] oldest;
            sat_pkg::slot_t             s;
            any = 1'b0;
            oldest = '0;
            slot = '0;
            for (int k = 0; k < sat_pkg::SLOT_COUNT; k++)
            begin
                s = scan_at(k);
                if (!locked(mask, s) && (!any || stamp[s] < oldest))
                begin
                    any = 1'b1;
                    oldest = stamp[s];
                    slot = s;
                end
            end
            if (any)
                clear_slot(slot);
            return any;
        endfunction

        function void note_command(logic [79:0] d);
            logic [2:0]                 op;
            sat_pkg::slot_t             idx;
            logic [sat_pkg::ID_W-1:0]   id;
            logic [sat_pkg::MASK_W-1:0] mask;
            logic [sat_pkg::TIME_W-1:0] now_us;
            reply_t                     r;
            sat_pkg::slot_t             s;
            sat_pkg::slot_t             hit;
            op = d[2:0];
            idx = sat_pkg::slot_t'(int'(d[5:3]) % sat_pkg::SLOT_COUNT);
            id = d[21:6];
            mask = d[29:22];
            now_us = d[77:30];
            r = '0;
            case (op)
                sat_pkg::CMD_SET_LAST:
                begin
                    last_slot = idx;
                    r.slot = 3'(idx);
                    r.found = 1'b1;
                end
                sat_pkg::CMD_CLAIM:
                begin
                    owner[idx] = id;
                    stamp[idx] = now_us;
                    in_use[idx] = 1'b1;
                    r.slot = 3'(idx);
                    r.found = 1'b1;
                end
                sat_pkg::CMD_NEXT:
                begin
                    r.slot = 3'(scan_at(0));
                    for (int k = 0; k < sat_pkg::SLOT_COUNT; k++)
                    begin
                        s = scan_at(k);
                        if (!locked(mask, s))
                        begin
                            r.slot = 3'(s);
                            r.found = 1'b1;
                            break;
                        end
                    end
                end
                sat_pkg::CMD_EVICT:
                begin
                    r.found = evict_oldest(mask, hit);
                    r.slot = 3'(hit);
                end
                sat_pkg::CMD_DELETE:
                begin
                    for (int k = 0; k < sat_pkg::SLOT_COUNT; k++)
                    begin
                        s = scan_at(k);
                        if (!locked(mask, s) && owner[s] == id)
                        begin
                            clear_slot(s);
                            r.slot = 3'(s);
                            r.found = 1'b1;
                            break;
                        end
                    end
                end
                sat_pkg::CMD_LOOKUP:
                begin
                    for (int k = 0; k < sat_pkg::SLOT_COUNT; k++)
                    begin
                        s = scan_at(k);
                        if (owner[s] == id)
                        begin
                            r.slot = 3'(s);
                            r.found = 1'b1;
                            r.running = locked(mask, s);
                            break;
                        end
                    end
                end
                sat_pkg::CMD_ALLOC:
                begin
                    for (int k = 0; k < sat_pkg::SLOT_COUNT; k++)
                    begin
                        s = scan_at(k);
                        if (!locked(mask, s) && !in_use[s])
                        begin
                            r.slot = 3'(s);
                            r.found = 1'b1;
                            break;
                        end
                    end
                    // With no free slot, allocate falls back to eviction.
                    if (!r.found)
                    begin
                        r.found = evict_oldest(mask, hit);
                        r.slot = 3'(hit);
                    end
                end
                default:
                begin
                end
            endcase
            last_reply = r;
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic [7:0] d);
            reply_t got;
            reply_t want;
            got = d[4:0];
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %h arrived with no command pending", d);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.slot != want.slot || got.found != want.found
                    || got.running != want.running)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: expected slot %0d found %0b running %0b",
                               want.slot, want.found, want.running);
                        $display(", got slot %0d found %0b running %0b",
                                 got.slot, got.found, got.running);
                    end
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    slot_table_tracker tracker = new();

    int                         send_idle = 0;
    int                         recv_idle = 0;
    int                         items_sent = 0;
    logic [sat_pkg::TIME_W-1:0] clock_us = '0;
    logic [sat_pkg::ID_W-1:0]   id_pool [8];

    slot_table_lru_allocator DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_reply(m_axis_tdata);
    end

    // Presents one command and returns at the edge where its transfer completes.
    task automatic send_command(input logic [2:0] op, input logic [2:0] idx,
                                input logic [sat_pkg::ID_W-1:0] id,
                                input logic [sat_pkg::MASK_W-1:0] mask,
                                input logic [sat_pkg::TIME_W-1:0] now_us);
        logic [79:0] d;
        d = {2'b00, now_us, mask, id, idx, op};
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_command(d);
        items_sent++;
    endtask

    function automatic logic [sat_pkg::MASK_W-1:0] pick_mask();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return NONE_LOCKED;
        else if (r == 2)
            return ALL_LOCKED;
        else if (r == 3)
            return ~(sat_pkg::MASK_W'(1) << $urandom_range(sat_pkg::MASK_W - 1));
        else if (r < 7)
            return sat_pkg::MASK_W'($urandom & $urandom);
        else
            return sat_pkg::MASK_W'($urandom);
    endfunction

    // Mostly rising time, with repeats for ties and rare jumps anywhere.
    function automatic logic [sat_pkg::TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return sat_pkg::TIME_W'({$urandom, $urandom});
        if (r >= 3)
            clock_us = clock_us + sat_pkg::TIME_W'($urandom_range(1, 5000));
        return clock_us;
    endfunction

    function automatic logic [sat_pkg::ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return id_pool[3'($urandom_range(7))];
        else if (r < 95)
            return sat_pkg::ID_W'($urandom);
        else
            return sat_pkg::EMPTY_OWNER;
    endfunction

    task automatic run_random(input int count);
        int          first;
        int          pick;
        logic [79:0] noise;
        first = items_sent;
        while (items_sent - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                send_command(sat_pkg::CMD_CLAIM, 3'($urandom), pick_id(), pick_mask(),
                             pick_time());
            else if (pick < 35)
            begin
                // Allocate a slot, then claim the one that was handed out.
                send_command(sat_pkg::CMD_ALLOC, 3'($urandom), sat_pkg::ID_W'($urandom),
                             pick_mask(), pick_time());
                if (tracker.last_reply.found)
                    send_command(sat_pkg::CMD_CLAIM, tracker.last_reply.slot, pick_id(),
                                 pick_mask(), pick_time());
            end
            else if (pick < 50)
                send_command(sat_pkg::CMD_LOOKUP, 3'($urandom), pick_id(), pick_mask(),
                             pick_time());
            else if (pick < 62)
                send_command(sat_pkg::CMD_DELETE, 3'($urandom), pick_id(), pick_mask(),
                             pick_time());
            else if (pick < 72)
                send_command(sat_pkg::CMD_EVICT, 3'($urandom), sat_pkg::ID_W'($urandom),
                             pick_mask(), pick_time());
            else if (pick < 80)
                send_command(sat_pkg::CMD_NEXT, 3'($urandom), sat_pkg::ID_W'($urandom),
                             pick_mask(), pick_time());
            else if (pick < 88)
                send_command(sat_pkg::CMD_SET_LAST, 3'($urandom), sat_pkg::ID_W'($urandom),
                             pick_mask(), pick_time());
            else if (pick < 93)
                id_pool[3'($urandom_range(7))] = sat_pkg::ID_W'($urandom);
            else if (pick < 97)
                send_command(CMD_UNUSED, 3'($urandom), sat_pkg::ID_W'($urandom),
                             sat_pkg::MASK_W'($urandom),
                             sat_pkg::TIME_W'({$urandom, $urandom}));
            else
            begin
                noise = 80'({$urandom, $urandom, $urandom});
                send_command(noise[2:0], noise[5:3], noise[21:6], noise[29:22],
                             noise[77:30]);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            id_pool[i] = sat_pkg::ID_W'($urandom);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 9;
        recv_idle = 84;

        // Empty table right after reset; an empty id matches an empty slot.
        send_command(sat_pkg::CMD_LOOKUP, 3'd0, sat_pkg::EMPTY_OWNER, NONE_LOCKED, '0);
        send_command(sat_pkg::CMD_LOOKUP, 3'd0, sat_pkg::EMPTY_OWNER, 8'h02, '0);
        // Every slot locked, then all but slot 0.
        send_command(sat_pkg::CMD_NEXT, 3'd0, 16'h0000, ALL_LOCKED, '0);
        send_command(sat_pkg::CMD_EVICT, 3'd0, 16'h0000, ALL_LOCKED, TIME_MAX);
        send_command(sat_pkg::CMD_ALLOC, 3'd0, 16'h0000, ALL_LOCKED, '0);
        send_command(sat_pkg::CMD_ALLOC, 3'd0, 16'h0000, 8'hFE, '0);
        // Fill the table; two pairs of slots share a claim time.
        send_command(sat_pkg::CMD_CLAIM, 3'd0, 16'h0000, NONE_LOCKED, TIME_MAX);
        send_command(sat_pkg::CMD_CLAIM, 3'd1, 16'hFFFE, NONE_LOCKED, 48'h0);
        send_command(sat_pkg::CMD_CLAIM, 3'd2, 16'h5555, NONE_LOCKED, 48'h10);
        send_command(sat_pkg::CMD_CLAIM, 3'd3, 16'hAAAA, NONE_LOCKED, 48'h0);
        send_command(sat_pkg::CMD_CLAIM, 3'd4, 16'h1234, NONE_LOCKED, 48'h800000000000);
        send_command(sat_pkg::CMD_CLAIM, 3'd5, 16'h8001, NONE_LOCKED, 48'h10);
        send_command(sat_pkg::CMD_CLAIM, 3'd6, 16'h00FF, NONE_LOCKED, 48'h555555555555);
        send_command(sat_pkg::CMD_CLAIM, 3'd7, 16'hFF00, NONE_LOCKED, 48'hAAAAAAAAAAAA);
        // No free slot left, so allocate evicts the oldest.
        send_command(sat_pkg::CMD_ALLOC, 3'd0, 16'h0000, NONE_LOCKED, '0);
        send_command(sat_pkg::CMD_SET_LAST, 3'd7, 16'h0000, NONE_LOCKED, '0);
        send_command(sat_pkg::CMD_NEXT, 3'd0, 16'h0000, 8'h01, '0);
        send_command(sat_pkg::CMD_LOOKUP, 3'd0, 16'hFFFE, NONE_LOCKED, '0);
        send_command(sat_pkg::CMD_LOOKUP, 3'd0, 16'h5555, 8'h04, '0);
        send_command(sat_pkg::CMD_DELETE, 3'd0, 16'hAAAA, 8'h08, '0);
        send_command(sat_pkg::CMD_DELETE, 3'd0, 16'hAAAA, NONE_LOCKED, '0);
        send_command(sat_pkg::CMD_EVICT, 3'd0, 16'h0000, NONE_LOCKED, '0);
        send_command(CMD_UNUSED, 3'd7, sat_pkg::EMPTY_OWNER, ALL_LOCKED, TIME_MAX);
        send_command(sat_pkg::CMD_CLAIM, 3'd7, sat_pkg::EMPTY_OWNER, ALL_LOCKED, TIME_MAX);
        send_command(sat_pkg::CMD_SET_LAST, 3'd0, 16'h0000, NONE_LOCKED, '0);

        run_random(RANDOM_PER_PHASE);
        send_idle = 84;
        recv_idle = 9;
        run_random(RANDOM_PER_PHASE);
        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_PER_PHASE);
        s_axis_tvalid <= 1'b0;

        while (tracker.expected_replies.size() != 0)
            @(posedge clk);
        repeat (2 * sat_pkg::SLOT_COUNT + 8) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
